// File: src/lsr_pkg.sv
// Shared types and constants of the line segment rasterizer.
package lsr_pkg;

  // Grid extent used for the inside flag.
  localparam int GRID_WIDTH  = 32;
  localparam int GRID_HEIGHT = 32;

  // Coordinate width on the ports, and the internal width with one guard bit.
  localparam int CoordW = 7;
  localparam int WideW  = CoordW + 1;

  // Width of the step counters and the last step index a segment may use.
  localparam int StepW       = 6;
  localparam int MaxStepLast = 63;

  typedef logic [CoordW-1:0]        coord_t;
  typedef logic signed [WideW-1:0]  wide_t;
  typedef logic [StepW-1:0]         step_t;

  // Request to and response from the serial divider.
  typedef struct packed {
    logic   start;
    coord_t dividend;
    coord_t divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    coord_t quot;
    coord_t rem;
  } div_rsp_t;

endpackage

// File: src/lsr_div.sv
// Serial restoring divider that produces one quotient bit per cycle.
module lsr_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsr_pkg::div_req_t req_i,
  output lsr_pkg::div_rsp_t rsp_o
);

  lsr_pkg::coord_t rem_q;
  lsr_pkg::coord_t quo_q;
  lsr_pkg::coord_t divisor_q;
  logic [2:0]      cnt_q;
  logic            busy_q;
  logic            done_q;

  logic [lsr_pkg::WideW-1:0] shifted;
  logic [lsr_pkg::WideW-1:0] diff;
  logic                      fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem_q, quo_q[lsr_pkg::CoordW-1]};
    fits    = shifted >= {1'b0, divisor_q};
    diff    = shifted - {1'b0, divisor_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      quo_q     <= '0;
      divisor_q <= '0;
      cnt_q     <= '0;
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rem_q     <= '0;
        quo_q     <= req_i.dividend;
        divisor_q <= req_i.divisor;
        cnt_q     <= '0;
        busy_q    <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? diff[lsr_pkg::CoordW-1:0] : shifted[lsr_pkg::CoordW-1:0];
        quo_q <= {quo_q[lsr_pkg::CoordW-2:0], fits};
        if (cnt_q == 3'(lsr_pkg::CoordW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// File: src/line_segment_rasterizer.sv
// Top level of the line segment rasterizer: sequencer, stepping unit and output register.
//
// The input channel takes one segment per word: start and end column and row, each a
// seven-bit two's complement value. The output channel gives one word per point of the
// segment, in order from the start point, with the point's column and row, a flag that
// says whether the point lies on the grid, and a last flag on the final point.
// A flat segment walks along x one column per point; any other segment gives |dy|+1
// points, each rounded half away from zero, and the walk stops after 64 points.
// After a segment is accepted the block passes through a setup state. A segment that is
// not flat then runs a serial divide of |dx| by |dy|, which sets the per point
// increment of x as a quotient and remainder, and picks up the result in the divide
// state. From then on one point is loaded into the output register per cycle while the
// receiver does not stall. The first point of a flat segment follows the setup state
// directly; any other segment waits for the divide to finish.
// in_stall_o is high from the accept until the last point is loaded into the output
// register, so the next segment can be taken while that point still waits. When the
// receiver stalls, the output word holds and the walk pauses. Reset clears the
// sequencer and drops out_valid_o; the block is ready as soon as reset is released.
module line_segment_rasterizer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [lsr_pkg::CoordW-1:0] x_start_i,
  input  logic signed [lsr_pkg::CoordW-1:0] y_start_i,
  input  logic signed [lsr_pkg::CoordW-1:0] x_end_i,
  input  logic signed [lsr_pkg::CoordW-1:0] y_end_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [lsr_pkg::CoordW-1:0] pixel_x_o,
  output logic signed [lsr_pkg::CoordW-1:0] pixel_y_o,
  output logic                             inside_res_o,
  output logic                             last_o
);

  typedef enum logic [1:0] {
    StIdle,
    StSetup,
    StDiv,
    StEmit
  } state_e;

  state_e state_q;

  // Latched endpoints: start column, start row, end column, end row.
  lsr_pkg::coord_t seg_q [4];

  lsr_pkg::step_t  step_idx_q;
  lsr_pkg::step_t  step_total_q;
  lsr_pkg::coord_t n_q;
  logic            dx_neg_q;

  // The x position is kept as a_q + r_q / n_q with 0 <= r_q < n_q.
  lsr_pkg::wide_t  a_q;
  lsr_pkg::coord_t r_q;
  lsr_pkg::wide_t  qd_q;
  lsr_pkg::coord_t rd_q;
  lsr_pkg::wide_t  y_q;
  lsr_pkg::wide_t  ystep_q;

  logic            out_valid_q;
  lsr_pkg::coord_t pixel_x_q;
  lsr_pkg::coord_t pixel_y_q;
  logic            inside_q;
  logic            last_q;

  lsr_pkg::div_req_t div_req;
  lsr_pkg::div_rsp_t div_rsp;

  // Segment setup values, taken from the latched endpoints.
  lsr_pkg::wide_t  x0, y0, x1, y1;
  lsr_pkg::wide_t  dx, dy, ndx, ndy;
  lsr_pkg::coord_t adx, ady, n_seg;
  logic            horiz;
  lsr_pkg::step_t  total_seg;
  lsr_pkg::wide_t  xsign, ysign;

  always_comb begin
    x0    = {seg_q[0][lsr_pkg::CoordW-1], seg_q[0]};
    y0    = {seg_q[1][lsr_pkg::CoordW-1], seg_q[1]};
    x1    = {seg_q[2][lsr_pkg::CoordW-1], seg_q[2]};
    y1    = {seg_q[3][lsr_pkg::CoordW-1], seg_q[3]};
    dx    = x1 - x0;
    dy    = y1 - y0;
    ndx   = -dx;
    ndy   = -dy;
    adx   = dx[lsr_pkg::WideW-1] ? ndx[lsr_pkg::CoordW-1:0] : dx[lsr_pkg::CoordW-1:0];
    ady   = dy[lsr_pkg::WideW-1] ? ndy[lsr_pkg::CoordW-1:0] : dy[lsr_pkg::CoordW-1:0];
    horiz = (dy == '0);
    n_seg = horiz ? adx : ady;
    // More than 64 points are cut to 64.
    total_seg = n_seg[lsr_pkg::CoordW-1] ? lsr_pkg::step_t'(lsr_pkg::MaxStepLast)
                                         : n_seg[lsr_pkg::StepW-1:0];
    xsign = (dx == '0) ? '0 : (dx[lsr_pkg::WideW-1] ? '1 : lsr_pkg::wide_t'(1));
    ysign = (dy == '0) ? '0 : (dy[lsr_pkg::WideW-1] ? '1 : lsr_pkg::wide_t'(1));
  end

  assign div_req.start    = (state_q == StSetup) && !horiz;
  assign div_req.dividend = adx;
  assign div_req.divisor  = ady;

  lsr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Turn the unsigned quotient of |dx| / |dy| into a floor quotient and remainder of dx.
  lsr_pkg::wide_t  quw, qplus, qd_div;
  lsr_pkg::coord_t rd_div;

  always_comb begin
    quw   = {1'b0, div_rsp.quot};
    qplus = quw + lsr_pkg::wide_t'(1);
    if (!dx_neg_q) begin
      qd_div = quw;
      rd_div = div_rsp.rem;
    end else if (div_rsp.rem != '0) begin
      qd_div = -qplus;
      rd_div = n_q - div_rsp.rem;
    end else begin
      qd_div = -quw;
      rd_div = '0;
    end
  end

  // Stepping unit: the current point, and the position of the next one.
  logic [lsr_pkg::WideW-1:0] rsum, rsub, r2, nz;
  logic                      carry, round_up;
  lsr_pkg::coord_t           r_next;
  lsr_pkg::wide_t            a_next, px;
  logic                      inside_pt, last_pt, emit;

  always_comb begin
    nz       = {1'b0, n_q};
    rsum     = {1'b0, r_q} + {1'b0, rd_q};
    carry    = rsum >= nz;
    rsub     = rsum - nz;
    r_next   = carry ? rsub[lsr_pkg::CoordW-1:0] : rsum[lsr_pkg::CoordW-1:0];
    a_next   = a_q + qd_q + lsr_pkg::wide_t'(carry);
    // Round half away from zero: a half rounds up only for a non-negative position.
    r2       = {r_q, 1'b0};
    round_up = a_q[lsr_pkg::WideW-1] ? (r2 > nz) : (r2 >= nz);
    px       = a_q + lsr_pkg::wide_t'(round_up);
    inside_pt = !px[lsr_pkg::WideW-1] &&
                (px[lsr_pkg::CoordW-1:0] < lsr_pkg::coord_t'(lsr_pkg::GRID_WIDTH)) &&
                !y_q[lsr_pkg::WideW-1] &&
                (y_q[lsr_pkg::CoordW-1:0] < lsr_pkg::coord_t'(lsr_pkg::GRID_HEIGHT));
    last_pt  = (step_idx_q == step_total_q);
    emit     = (state_q == StEmit) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      seg_q        <= '{default: '0};
      step_idx_q   <= '0;
      step_total_q <= '0;
      n_q          <= '0;
      dx_neg_q     <= 1'b0;
      a_q          <= '0;
      r_q          <= '0;
      qd_q         <= '0;
      rd_q         <= '0;
      y_q          <= '0;
      ystep_q      <= '0;
      out_valid_q  <= 1'b0;
      pixel_x_q    <= '0;
      pixel_y_q    <= '0;
      inside_q     <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            seg_q[0] <= x_start_i;
            seg_q[1] <= y_start_i;
            seg_q[2] <= x_end_i;
            seg_q[3] <= y_end_i;
            state_q  <= StSetup;
          end
        end
        StSetup: begin
          a_q          <= x0;
          y_q          <= y0;
          r_q          <= '0;
          ystep_q      <= ysign;
          step_idx_q   <= '0;
          step_total_q <= total_seg;
          dx_neg_q     <= dx[lsr_pkg::WideW-1];
          if (horiz) begin
            // A flat walk moves one whole column per point with no remainder.
            n_q     <= lsr_pkg::coord_t'(1);
            qd_q    <= xsign;
            rd_q    <= '0;
            state_q <= StEmit;
          end else begin
            n_q     <= ady;
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (div_rsp.done) begin
            qd_q    <= qd_div;
            rd_q    <= rd_div;
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (emit) begin
            a_q        <= a_next;
            r_q        <= r_next;
            y_q        <= y_q + ystep_q;
            step_idx_q <= step_idx_q + lsr_pkg::step_t'(1);
            if (last_pt) begin
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase

      if (emit) begin
        out_valid_q <= 1'b1;
        pixel_x_q   <= px[lsr_pkg::CoordW-1:0];
        pixel_y_q   <= y_q[lsr_pkg::CoordW-1:0];
        inside_q    <= inside_pt;
        last_q      <= last_pt;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o   = (state_q != StIdle);
  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = pixel_x_q;
  assign pixel_y_o    = pixel_y_q;
  assign inside_res_o = inside_q;
  assign last_o       = last_q;

endmodule

// File: sim/lsr_point_monitor.sv
// Monitor that predicts the points of each accepted segment and compares the output words.
`timescale 1ns / 100ps

module lsr_point_monitor
  import lsr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic signed [CoordW-1:0] x_start_i,
  input  logic signed [CoordW-1:0] y_start_i,
  input  logic signed [CoordW-1:0] x_end_i,
  input  logic signed [CoordW-1:0] y_end_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [CoordW-1:0] pixel_x_i,
  input  logic signed [CoordW-1:0] pixel_y_i,
  input  logic                     inside_res_i,
  input  logic                     last_i,
  output int                       fail_count_o,
  output int                       points_pending_o
);

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   in_grid;
    logic   last;
  } point_t;

  point_t expected_points[$];
  int     fail_count = 0;

  // Divide and round half away from zero; den is always positive.
  function automatic int round_half_away(int num, int den);
    if (num >= 0) begin
      return (2 * num + den) / (2 * den);
    end
    return -((2 * (-num) + den) / (2 * den));
  endfunction

  // Queue every point that one segment produces, in walking order.
  function automatic void rasterize_segment(coord_t xs, coord_t ys, coord_t xe, coord_t ye);
    int     x0, y0, x1, y1, dx, dy, span, count, px, py;
    bit     flat;
    point_t p;
    x0    = int'($signed(xs));
    y0    = int'($signed(ys));
    x1    = int'($signed(xe));
    y1    = int'($signed(ye));
    dx    = x1 - x0;
    dy    = y1 - y0;
    flat  = (dy == 0);
    span  = flat ? ((dx < 0) ? -dx : dx) : ((dy < 0) ? -dy : dy);
    count = (span + 1 > MaxStepLast + 1) ? MaxStepLast + 1 : span + 1;
    for (int i = 0; i < count; i++) begin
      if (flat) begin
        px = (x0 < x1) ? x0 + i : x0 - i;
        py = y1;
      end else begin
        px = round_half_away(x0 * span + i * dx, span);
        py = round_half_away(y0 * span + i * dy, span);
      end
      p.x       = px[CoordW-1:0];
      p.y       = py[CoordW-1:0];
      p.in_grid = (px >= 0) && (px < GRID_WIDTH) && (py >= 0) && (py < GRID_HEIGHT);
      p.last    = (i == count - 1);
      expected_points = {expected_points, p};
    end
  endfunction

  function automatic int field_mismatch(string field, int want_v, int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin : watch
    point_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word, expected none, actual x=%0d y=%0d grid=%0b last=%0b",
                   $time, pixel_x_i, pixel_y_i, inside_res_i, last_i);
        end else begin
          want = expected_points.pop_front();
          fail_count += field_mismatch("pixel_x", int'($signed(want.x)), int'(pixel_x_i));
          fail_count += field_mismatch("pixel_y", int'($signed(want.y)), int'(pixel_y_i));
          fail_count += field_mismatch("inside_res", int'(want.in_grid), int'(inside_res_i));
          fail_count += field_mismatch("last", int'(want.last), int'(last_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        rasterize_segment(x_start_i, y_start_i, x_end_i, y_end_i);
      end
    end
    fail_count_o     <= fail_count;
    points_pending_o <= expected_points.size();
  end

endmodule

// File: sim/tb_top.sv
// Testbench top of the line segment rasterizer: clock, reset, segment stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import lsr_pkg::*;

  localparam int RandomSegments = 460;
  // The slowest legal run is well under this limit: every segment at 64 points with
  // the receiver in its heaviest stall mode and the sender at its longest gaps.
  localparam int CycleLimit     = 1_000_000;
  // The first point of a segment is loaded after the setup state and, unless it is flat, the divide,
  // so this is ample time for a stray word to show up once nothing is expected any more.
  localparam int DrainCycles    = 24;

  // The receiver switches between these stall patterns at random intervals.
  typedef enum int {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [CoordW-1:0] x_start_i;
  logic signed [CoordW-1:0] y_start_i;
  logic signed [CoordW-1:0] x_end_i;
  logic signed [CoordW-1:0] y_end_i;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [CoordW-1:0] pixel_x_o;
  logic signed [CoordW-1:0] pixel_y_o;
  logic                     inside_res_o;
  logic                     last_o;

  int          fail_count;
  int          points_pending;
  int          cycle_count = 0;
  int          burst_left  = 0;
  stall_mode_e stall_mode  = StallNone;
  int          mode_left   = 0;

  line_segment_rasterizer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .inside_res_o (inside_res_o),
    .last_o       (last_o)
  );

  lsr_point_monitor u_point_mon (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .x_start_i        (x_start_i),
    .y_start_i        (y_start_i),
    .x_end_i          (x_end_i),
    .y_end_i          (y_end_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pixel_x_i        (pixel_x_o),
    .pixel_y_i        (pixel_y_o),
    .inside_res_i     (inside_res_o),
    .last_i           (last_o),
    .fail_count_o     (fail_count),
    .points_pending_o (points_pending)
  );

  // 12 ns clock period.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Watchdog: a hung handshake or a lost point ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver stall pattern. It runs on its own, independent of the sender, so stalls land
  // on every phase of a segment: during setup, the divide, the walk and the last point.
  // The free mode gives stretches in which every output word is taken at once.
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      mode_left  <= $urandom_range(16, 160);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      StallNone: begin
        out_stall_i <= 1'b0;
      end
      StallLight: begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
      StallHeavy: begin
        out_stall_i <= ($urandom_range(0, 1) == 1);
      end
      default: begin
        out_stall_i <= ((cycle_count % 7) < 3);
      end
    endcase
  end

  // Present one segment word and hold it until it is taken. The sender works in bursts:
  // while a burst lasts, the next word follows right at the accepting edge with valid
  // kept high; at the end of a burst valid drops for a random gap.
  task automatic send_segment(input int xs, input int ys, input int xe, input int ye);
    in_valid_i <= 1'b1;
    x_start_i  <= xs[CoordW-1:0];
    y_start_i  <= ys[CoordW-1:0];
    x_end_i    <= xe[CoordW-1:0];
    y_end_i    <= ye[CoordW-1:0];
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // Random segments. Most are short so that many segments go through in reasonable time;
  // some span the whole grid, and a few use the full seven-bit range so that every input
  // bit toggles and the walk gets cut at 64 points.
  task automatic send_random_segment();
    int kind, xs, ys, xe, ye;
    kind = $urandom_range(0, 99);
    xs   = int'($urandom_range(0, 63)) - 16;
    ys   = int'($urandom_range(0, 63)) - 16;
    if (kind < 35) begin
      xe = xs + int'($urandom_range(0, 16)) - 8;
      ye = ys + int'($urandom_range(0, 16)) - 8;
    end else if (kind < 50) begin
      // Flat segment, walked column by column in either direction.
      xe = xs + int'($urandom_range(0, 24)) - 12;
      ye = ys;
    end else if (kind < 58) begin
      // Both endpoints equal: a single point.
      xe = xs;
      ye = ys;
    end else if (kind < 68) begin
      // Steep segment with a small x change, which exercises the rounding.
      xe = xs + int'($urandom_range(0, 4)) - 2;
      ye = ys + int'($urandom_range(0, 30)) - 15;
    end else if (kind < 90) begin
      xe = int'($urandom_range(0, 63)) - 16;
      ye = int'($urandom_range(0, 63)) - 16;
    end else begin
      xs = int'($urandom_range(0, 127)) - 64;
      ys = int'($urandom_range(0, 127)) - 64;
      xe = int'($urandom_range(0, 127)) - 64;
      ye = int'($urandom_range(0, 127)) - 64;
    end
    send_segment(xs, ys, xe, ye);
  endtask

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    x_start_i  <= '0;
    y_start_i  <= '0;
    x_end_i    <= '0;
    y_end_i    <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed segments. Single points at both ends of the coordinate range.
    send_segment(0, 0, 0, 0);
    send_segment(-64, -64, -64, -64);
    send_segment(63, 63, 63, 63);
    // Flat walks to the right, to the left, and one wholly off the grid.
    send_segment(0, 5, 31, 5);
    send_segment(31, 31, 0, 31);
    send_segment(-16, 40, 47, 40);
    // Vertical walks down and up, and both diagonals.
    send_segment(3, 0, 3, 31);
    send_segment(3, 31, 3, 0);
    send_segment(0, 0, 31, 31);
    send_segment(31, 0, 0, 31);
    // Exact halves, which must round away from zero on both signs.
    send_segment(0, 0, 1, 2);
    send_segment(0, 0, -1, 2);
    send_segment(-3, 0, -4, 2);
    // Shallow slopes, which leave gaps in x.
    send_segment(0, 0, 40, 3);
    send_segment(47, -16, -16, -13);
    // Exactly 64 points, flat and not flat: the walk is not cut yet.
    send_segment(0, 0, 63, 0);
    send_segment(0, -32, 10, 31);
    // More than 64 points: the walk is cut and the end point never shows.
    send_segment(-64, -64, 63, 63);
    send_segment(-64, 0, 63, 0);
    send_segment(0, -64, 0, 63);
    // Points off the grid and on its edges.
    send_segment(32, 32, 40, 45);
    send_segment(31, 31, 32, 32);
    send_segment(-1, -1, 0, 0);

    for (int n = 0; n < RandomSegments; n++) begin
      send_random_segment();
    end

    // Let the monitor see the last accept before looking at what is still expected.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (points_pending != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
